>>> src/fss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer package
// Widths, scoring constants, register codes and byte classification helpers.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int MAX_NEEDLE_DEF = 24;
  localparam int NEEDLE_LEN_W   = 5;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 2;
  localparam int CHARS_PER_WORD = 8;
  localparam int SUM_W          = 11;
  localparam int SCORE_W        = 12;
  localparam int GAP_W          = 7;

  localparam logic [SUM_W-1:0]   SUM_MAX     = '1;
  localparam logic [GAP_W-1:0]   GAP_MAX     = '1;
  localparam logic [SCORE_W-1:0] BASE_BONUS  = 12'd1;
  localparam logic [SCORE_W-1:0] DELIM_BONUS = 12'd8;
  localparam logic [SCORE_W-1:0] START_BONUS = 12'd6;
  localparam int                 RUN_SHIFT   = 2;   // run weight of 4
  localparam int                 GAP_SHIFT   = 2;   // gap divided by 4

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEEDLE_LEN = 2'd0,
    REG_CHARS_LO   = 2'd1,
    REG_CHARS_MID  = 2'd2,
    REG_CHARS_HI   = 2'd3
  } cfg_reg_t;

  function automatic logic is_boundary(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_SLASH) || (b == CH_UNDER) ||
           (b == CH_DASH)  || (b == CH_COLON) || (b == CH_DOT);
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    return ((b >= CH_UP_A) && (b <= CH_UP_Z)) ? b + CASE_OFS : b;
  endfunction

endpackage

>>> src/fuzzy_subsequence_scorer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer core
// Scores a streamed label against a configured lowercase needle.
// ----------------------------------------------------------------------------
// Takes one label byte per cycle while no last byte is held. Each accepted
// word waits in an input register, then a single compare-and-add stage
// updates the match state; the word that carries last_byte loads the result
// register, so out_valid rises when that word leaves the input register.
// Only a last byte can stall, and only while the previous result is unread.
// The needle is written through the cfg port between labels or mid-label;
// a new needle length applies from the next byte.
module fuzzy_subsequence_scorer_core
  import fss_pkg::*;
#(
  parameter int MAX_NEEDLE = MAX_NEEDLE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                hay_byte,
  input  logic                      last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      matched,
  output logic signed [SCORE_W-1:0] score
);

  localparam int POS_W = $clog2(MAX_NEEDLE + 1);
  localparam logic [NEEDLE_LEN_W-1:0] LEN_CAP = NEEDLE_LEN_W'(MAX_NEEDLE);

  logic [NEEDLE_LEN_W-1:0]      needle_len;
  logic [7:0]                   needle [MAX_NEEDLE];

  logic                         s1_valid;
  logic [7:0]                   s1_byte;
  logic                         s1_last;
  logic                         s1_adv;

  logic [POS_W-1:0]             pos, pos_next;
  logic [POS_W-1:0]             run, run_next;
  logic [GAP_W-1:0]             gap, gap_next;
  logic [SUM_W-1:0]             sum, sum_next;
  logic                         prev_bnd, prev_bnd_next;
  logic                         at_first;

  logic [POS_W-1:0]             len_eff;
  logic [7:0]                   cur_char;
  logic                         active, hit;
  logic [SCORE_W-1:0]           bonus, sum_ext;
  logic                         res_ok;
  logic [SCORE_W-1:0]           res_score;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_len <= '0;
    end else if (cfg_wen && (cfg_index == REG_NEEDLE_LEN)) begin
      needle_len <= cfg_data[NEEDLE_LEN_W-1:0];
    end
  end

  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_needle
    localparam int WORD = i / CHARS_PER_WORD;
    localparam int LANE = i % CHARS_PER_WORD;
    localparam logic [CFG_INDEX_W-1:0] CODE = CFG_INDEX_W'(REG_CHARS_LO + WORD);
    always_ff @(posedge clk) begin
      if (rst) begin
        needle[i] <= '0;
      end else if (cfg_wen && (cfg_index == CODE)) begin
        needle[i] <= cfg_data[LANE*8 +: 8];
      end
    end
  end

  assign len_eff = (needle_len > LEN_CAP) ? POS_W'(MAX_NEEDLE)
                                          : needle_len[POS_W-1:0];

  // ---- input register ----
  assign s1_adv   = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= hay_byte;
      s1_last <= last_byte;
    end
  end

  // ---- match update ----
  always_comb begin
    cur_char = '0;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      if (pos == POS_W'(i)) cur_char = needle[i];
    end
  end

  assign active = pos < len_eff;
  assign hit    = active && (fold_lower(s1_byte) == cur_char);

  always_comb begin
    bonus = BASE_BONUS + (SCORE_W'(run) << RUN_SHIFT);
    if (prev_bnd) bonus = bonus + DELIM_BONUS;
    if ((pos == '0) && at_first) bonus = bonus + START_BONUS;
    sum_ext = {1'b0, sum} + bonus;

    pos_next      = pos;
    run_next      = run;
    gap_next      = gap;
    sum_next      = sum;
    prev_bnd_next = prev_bnd;
    if (active) begin
      prev_bnd_next = is_boundary(s1_byte);
      if (hit) begin
        pos_next = pos + POS_W'(1);
        run_next = run + POS_W'(1);
        sum_next = sum_ext[SCORE_W-1] ? SUM_MAX : sum_ext[SUM_W-1:0];
      end else begin
        run_next = '0;
        if ((pos == '0) && (gap != GAP_MAX)) gap_next = gap + GAP_W'(1);
      end
    end

    res_ok    = pos_next >= len_eff;
    res_score = '0;
    if ((len_eff != '0) && res_ok) begin
      res_score = {1'b0, sum_next} - SCORE_W'(gap_next >> GAP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      run      <= '0;
      gap      <= '0;
      sum      <= '0;
      prev_bnd <= 1'b1;
      at_first <= 1'b1;
    end else if (s1_adv) begin
      if (s1_last) begin
        pos      <= '0;
        run      <= '0;
        gap      <= '0;
        sum      <= '0;
        prev_bnd <= 1'b1;
        at_first <= 1'b1;
      end else begin
        pos      <= pos_next;
        run      <= run_next;
        gap      <= gap_next;
        sum      <= sum_next;
        prev_bnd <= prev_bnd_next;
        at_first <= 1'b0;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_last) begin
      matched <= res_ok;
      score   <= res_score;
    end
  end

  // ---- checks ----
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_NEEDLE))
    else $error("needle position beyond needle storage");

  a_run_le_pos: assert property (@(posedge clk) disable iff (rst)
    run <= pos)
    else $error("match run longer than matched prefix");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> score == '0)
    else $error("nonzero score on unmatched label");

  a_last_loads: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> out_valid && pos == '0 && at_first)
    else $error("last word did not post result and clear state");

endmodule

>>> tb/sv/fuzzy_subsequence_scorer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer core testbench
// Streams labels through the core under several needle settings and checks
// every matched flag and score against a cycle-free scoring model kept in
// the bench, with random idling on both sides.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_core_test;
  import fss_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 50;
  localparam logic [7:0] SEPS [0:5] = '{CH_SPACE, CH_SLASH, CH_UNDER, CH_DASH,
                                        CH_COLON, CH_DOT};

  typedef struct {
    logic [7:0] b;
    logic       last;
  } hay_word_t;

  typedef struct {
    logic                      m;
    logic signed [SCORE_W-1:0] sc;
  } label_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                hay_byte = 8'h00;
  logic                      last_byte = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      matched;
  logic signed [SCORE_W-1:0] score;

  fuzzy_subsequence_scorer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .hay_byte (hay_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .matched  (matched),
    .score    (score)
  );

  hay_word_t     pending[$];
  label_result_t results_due[$];
  logic [7:0]    label_buf[$];

  // needle registers as written
  logic [NEEDLE_LEN_W-1:0] needle_len_q = '0;
  logic [63:0]             needle_words [0:2] = '{64'h0, 64'h0, 64'h0};

  // per-label match state
  int unsigned pos_q   = 0;
  int unsigned run_q   = 0;
  int unsigned gap_q   = 0;
  logic [7:0]  prev_q  = CH_SPACE;
  int unsigned sum_q   = 0;
  logic        first_q = 1'b1;

  int errors        = 0;
  int words_queued  = 0;
  int words_in      = 0;
  int labels_scored = 0;
  int settings      = 0;
  int stall_cycles  = 0;
  bit calm          = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, labels_scored);
    errors++;
  endtask

  function automatic int unsigned active_len();
    return (needle_len_q > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : needle_len_q;
  endfunction

  // Update the match state for one word; a last word queues its result.
  task automatic score_byte(input logic [7:0] hb, input logic last);
    int unsigned   len;
    int unsigned   gain;
    logic [7:0]    folded;
    logic [7:0]    want;
    label_result_t r;
    len = active_len();
    if (pos_q < len) begin
      folded = (hb >= CH_UP_A && hb <= CH_UP_Z) ? hb + CASE_OFS : hb;
      want = needle_words[pos_q >> 3][8 * (pos_q & 7) +: 8];
      if (folded == want) begin
        gain = BASE_BONUS + (run_q << RUN_SHIFT);
        if (prev_q == CH_SPACE || prev_q == CH_SLASH || prev_q == CH_UNDER ||
            prev_q == CH_DASH || prev_q == CH_COLON || prev_q == CH_DOT)
          gain += DELIM_BONUS;
        if (pos_q == 0 && first_q)
          gain += START_BONUS;
        sum_q += gain;
        if (sum_q > SUM_MAX)
          sum_q = SUM_MAX;
        pos_q = (pos_q + 1) & 31;
        if (run_q < 31)
          run_q++;
      end else begin
        run_q = 0;
        if (pos_q == 0 && gap_q < GAP_MAX)
          gap_q++;
      end
      prev_q = hb;
    end
    first_q = 1'b0;
    if (last) begin
      r.m  = (pos_q >= len);
      r.sc = (len != 0 && r.m) ? SCORE_W'(int'(sum_q) - int'(gap_q >> GAP_SHIFT)) : '0;
      results_due.insert(results_due.size(), r);
      pos_q   = 0;
      run_q   = 0;
      gap_q   = 0;
      prev_q  = CH_SPACE;
      sum_q   = 0;
      first_q = 1'b1;
    end
  endtask

  always @(posedge clk) begin : driver
    hay_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
        w = pending.pop_front();
        in_valid  <= 1'b1;
        hay_byte  <= w.b;
        last_byte <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin : monitor
    label_result_t want_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report("result with none due", score, 0);
        end else begin
          want_r = results_due.pop_front();
          if (matched !== want_r.m)
            report("matched", matched, want_r.m);
          if (score !== want_r.sc)
            report("score", score, want_r.sc);
        end
        labels_scored++;
      end
      if (in_valid && in_ready) begin
        score_byte(hay_byte, last_byte);
        words_in++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT after %0d cycles without a handshake", stall_cycles);
      $display("fuzzy_subsequence_scorer_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_NEEDLE_LEN)
      needle_len_q = data[NEEDLE_LEN_W-1:0];
    else
      needle_words[idx - 1] = data;
  endtask

  task automatic load_needle(input logic [63:0] len_word, input logic [63:0] w0,
                             input logic [63:0] w1, input logic [63:0] w2);
    write_reg(REG_CHARS_HI, w2);
    write_reg(REG_NEEDLE_LEN, len_word);
    write_reg(REG_CHARS_MID, w1);
    write_reg(REG_CHARS_LO, w0);
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  // wait until no word is pending and every result is in
  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    label_buf.insert(label_buf.size(), b);
  endtask

  task automatic end_label();
    hay_word_t w;
    for (int i = 0; i < label_buf.size(); i++) begin
      w.b    = label_buf[i];
      w.last = (i == label_buf.size() - 1);
      pending.insert(pending.size(), w);
    end
    words_queued += label_buf.size();
    label_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_needle_char();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 80) return 8'h61 + 8'($urandom_range(25));
    if (k < 90) return SEPS[$urandom_range(5)];
    if (k < 95) return CH_UP_A + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_filler();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 40) return 8'($urandom_range(255));
    if (k < 60) return SEPS[$urandom_range(5)];
    if (k < 80) return 8'h61 + 8'($urandom_range(25));
    return CH_UP_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [63:0] pick_needle_word();
    logic [63:0] w;
    for (int i = 0; i < CHARS_PER_WORD; i++)
      w[8*i +: 8] = pick_needle_char();
    return w;
  endfunction

  // mostly the needle in order with random filler; some broken or pure noise
  task automatic make_label();
    int unsigned kind;
    int unsigned len;
    int          skip;
    logic [7:0]  c;
    kind = $urandom_range(99);
    len  = active_len();
    if (kind < 10) begin
      repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(255)));
    end else begin
      skip = (kind < 25 && len > 0) ? int'($urandom_range(len - 1)) : -1;
      if ($urandom_range(99) < 4)
        repeat ($urandom_range(100, 135)) add_byte(pick_filler());
      for (int i = 0; i < int'(len); i++) begin
        repeat ($urandom_range(0, 3)) add_byte(pick_filler());
        if (i != skip) begin
          c = needle_words[i >> 3][8 * (i & 7) +: 8];
          if (c >= 8'h61 && c <= 8'h7a && $urandom_range(1))
            c = c - CASE_OFS;
          add_byte(c);
        end
      end
      repeat ($urandom_range(0, 3)) add_byte(pick_filler());
    end
    if (label_buf.size() == 0)
      add_byte(pick_filler());
    end_label();
  endtask

  initial begin : stimulus
    logic [63:0] len_word;
    logic [7:0]  pad;
    int unsigned len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty needle straight out of reset
    add_text("x");
    end_label();
    drain();

    // case folding, first byte bonus, runs, separators, no match, byte extremes
    load_needle(64'd3, 64'h0000_0000_0063_6261, 64'h0, 64'h0);
    add_text("Abc");
    end_label();
    add_text("_a-b.c");
    end_label();
    add_text("zzab");
    end_label();
    add_byte(8'hff);
    end_label();
    add_byte(8'h00);
    end_label();
    add_text("a:B/c");
    end_label();
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0, 9:    len = MAX_NEEDLE_DEF;
        1:       len = 31;
        2:       len = 1;
        3:       len = 0;
        default: len = $urandom_range(1, MAX_NEEDLE_DEF);
      endcase
      len_word = {$urandom, $urandom};
      len_word[NEEDLE_LEN_W-1:0] = len[NEEDLE_LEN_W-1:0];
      load_needle(len_word, pick_needle_word(), pick_needle_word(), pick_needle_word());
      calm = (ph == 5);
      if (ph == 2) begin
        // long leading gap saturates and drives the score negative
        do pad = 8'h61 + 8'($urandom_range(25));
        while (pad == needle_words[0][7:0] || pad == SEPS[0]);
        repeat (130) add_byte(pad);
        add_byte(needle_words[0][7:0]);
        end_label();
      end
      words_queued = 0;
      while (words_queued < PHASE_WORDS)
        make_label();
      if (ph == 6) begin
        // hold off mid-phase until every result is back
        drain();
        words_queued = 0;
        while (words_queued < PHASE_WORDS / 2)
          make_label();
      end
      drain();
      calm = 1'b0;
    end

    repeat (8) @(negedge clk);
    if (results_due.size() != 0)
      report("results never delivered", 0, results_due.size());
    $display("Scored %0d labels from %0d words over %0d needle settings", labels_scored,
             words_in, settings);
    $display("Needle lengths included empty, one, full and over-range; errors: %0d", errors);
    if (errors == 0) begin
      $display("fuzzy_subsequence_scorer_core verification clean");
    end else begin
      $display("fuzzy_subsequence_scorer_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/fss_pkg.sv
src/fuzzy_subsequence_scorer_core.sv
tb/sv/fuzzy_subsequence_scorer_core_test.sv
